>>> hdl/sector_scan_converter_defines.svh
// Assertion helpers shared by the sector scan converter RTL.
`ifndef SECTOR_SCAN_CONVERTER_DEFINES_SVH
`define SECTOR_SCAN_CONVERTER_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define SCC_ASSERT_SAME(lbl, clk, rst, cond, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

// Condition implies consequence in the next cycle.
`define SCC_ASSERT_NEXT(lbl, clk, rst, cond, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

>>> hdl/scc_pkg.sv
package scc_pkg;

   localparam int MAX_BEAMS    = 128;
   localparam int SAMPLE_DEPTH = 400;
   localparam int IMAGE_WIDTH  = 512;

   localparam int BEAM_W      = $clog2(MAX_BEAMS);
   localparam int COUNT_W     = 8;
   localparam int SIDX_W      = $clog2(SAMPLE_DEPTH);
   localparam int STORE_DEPTH = MAX_BEAMS * SAMPLE_DEPTH;
   localparam int SADDR_W     = $clog2(STORE_DEPTH);

   // Rotated coordinates carry 18 fraction bits.
   localparam int ROT_W  = 36;
   localparam int CMP_W  = 40;
   localparam int FRAC_W = 18;

   localparam logic [7:0] BACKGROUND = 8'hFF;
   localparam logic [8:0] AMP_LIMIT  = 9'd250;

   localparam logic [1:0] OP_LOAD_GEOM  = 2'd0;
   localparam logic [1:0] OP_WRITE_SAMP = 2'd1;
   localparam logic [1:0] OP_RENDER     = 2'd2;

   typedef struct packed {
      logic signed [14:0] origin;
      logic signed [15:0] cos_v;
      logic signed [15:0] sin_v;
   } geom_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_EVAL,
      ST_RD0,
      ST_RD1,
      ST_CALC,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      SEL_FIRST,
      SEL_AVG,
      SEL_SECOND
   } sel_type;

endpackage

>>> hdl/scc_geom_mem.sv
module scc_geom_mem
   import scc_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [BEAM_W-1:0] wr_addr,
   input  geom_type          wr_data,
   input  logic              rd_en,
   input  logic [BEAM_W-1:0] rd_addr,
   output geom_type          rd_data
);

   geom_type mem [MAX_BEAMS];
   geom_type rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/scc_sample_mem.sv
module scc_sample_mem
   import scc_pkg::*;
(
   input  logic               clock,
   input  logic               wr_en,
   input  logic [SADDR_W-1:0] wr_addr,
   input  logic [7:0]         wr_data,
   input  logic               rd_en,
   input  logic [SADDR_W-1:0] rd_addr,
   output logic [7:0]         rd_data
);

   logic [7:0] mem [STORE_DEPTH];
   logic [7:0] rd_data_ff;

   // Waveform bytes of all beams, beam-major.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/sector_scan_converter.sv
// Channel    Direction  Handshake          Payload
// request    in         req_valid/ready    req_opcode .. req_pixel_y
// response   out        rsp_valid/ready    rsp_pixel_value
// csr        in         csr_wr_en          csr_wr_data (beam count)
//
// Loads and sample writes are done as the request is taken. A render holds
// the input while it walks the beams up to the first one whose rotated x is
// negative, or to the last beam: the beam walk reads one geometry entry per
// cycle. Background cases found before the walk go straight to the finish.
// Reset is synchronous; the stores have no reset. One request is in work at
// a time; a finished pixel waits in the output register while the next
// request is taken.
`include "sector_scan_converter_defines.svh"

module sector_scan_converter
   import scc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_opcode,
   input  logic [6:0]         req_beam_index,
   input  logic signed [14:0] req_beam_origin_x,
   input  logic signed [15:0] req_beam_cos,
   input  logic signed [15:0] req_beam_sin,
   input  logic [8:0]         req_sample_index,
   input  logic [7:0]         req_sample_value,
   input  logic [8:0]         req_pixel_x,
   input  logic [8:0]         req_pixel_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_pixel_value,
   input  logic               csr_wr_en,
   input  logic [7:0]         csr_wr_data
);

   state_type state_ff, state_in;

   logic [COUNT_W-1:0] beam_count_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [8:0]         px_ff, px_in;
   logic [8:0]         py_ff, py_in;
   logic [COUNT_W-1:0] issue_ff, issue_in;
   logic               valid_a_ff, valid_a_in;
   logic               valid_b_ff, valid_b_in;
   logic [COUNT_W-1:0] idx_a_ff, idx_a_in;
   logic [COUNT_W-1:0] idx_b_ff, idx_b_in;
   logic signed [ROT_W-1:0] p_xc_ff, p_xc_in, p_ys_ff, p_ys_in;
   logic signed [ROT_W-1:0] p_yc_ff, p_yc_in, p_xs_ff, p_xs_in;
   logic signed [ROT_W-1:0] last_xr_ff, last_xr_in, last_yr_ff, last_yr_in;
   logic signed [ROT_W-1:0] x0_ff, x0_in, x1_ff, x1_in;
   logic signed [ROT_W-1:0] yr0_ff, yr0_in, yr1_ff, yr1_in;
   logic [BEAM_W-1:0]  beam_ff, beam_in;
   logic [SIDX_W-1:0]  n0_ff, n0_in, n1_ff, n1_in;
   sel_type            sel_ff, sel_in;
   logic [7:0]         v0_ff, v0_in;
   logic [7:0]         result_ff, result_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_value_ff, rsp_value_in;

   logic               req_fire;
   geom_type           geom_wr, geom_rd;
   logic               geom_rd_en;
   logic               samp_wr_en, samp_rd_en;
   logic [SADDR_W-1:0] samp_wr_addr, samp_rd_addr;
   logic [7:0]         samp_rd_data;
   logic signed [16:0] dx;
   logic signed [13:0] py16;
   logic signed [ROT_W-1:0] xr, yr, t0, t1;
   logic signed [CMP_W-1:0] dd, x0_4, d_3;
   logic               ok0, ok1;
   logic [8:0]         avg;

   assign req_fire  = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel_value = rsp_value_ff;

   // Stores: geometry per beam and waveform bytes.
   assign geom_wr = '{origin: req_beam_origin_x, cos_v: req_beam_cos, sin_v: req_beam_sin};
   assign samp_wr_en = req_fire && (req_opcode == OP_WRITE_SAMP)
                       && (int'(req_beam_index) < MAX_BEAMS)
                       && (int'(req_sample_index) < SAMPLE_DEPTH);
   assign samp_wr_addr = SADDR_W'(req_beam_index) * SADDR_W'(SAMPLE_DEPTH)
                         + SADDR_W'(req_sample_index);
   assign geom_rd_en = (state_ff == ST_WALK) && (issue_ff < count_ff);

   scc_geom_mem u_geom (
      .clock   (clock),
      .wr_en   (req_fire && (req_opcode == OP_LOAD_GEOM)
                && (int'(req_beam_index) < MAX_BEAMS)),
      .wr_addr (BEAM_W'(req_beam_index)),
      .wr_data (geom_wr),
      .rd_en   (geom_rd_en),
      .rd_addr (issue_ff[BEAM_W-1:0]),
      .rd_data (geom_rd)
   );

   scc_sample_mem u_samp (
      .clock   (clock),
      .wr_en   (samp_wr_en),
      .wr_addr (samp_wr_addr),
      .wr_data (req_sample_value),
      .rd_en   (samp_rd_en),
      .rd_addr (samp_rd_addr),
      .rd_data (samp_rd_data)
   );

   // Rotation products of the geometry entry that just came out of the store.
   assign dx   = $signed({4'b0, px_ff, 4'b0}) - 17'(geom_rd.origin);
   assign py16 = $signed({1'b0, py_ff, 4'b0});
   assign p_xc_in = ROT_W'(dx * geom_rd.cos_v);
   assign p_ys_in = ROT_W'(py16 * geom_rd.sin_v);
   assign p_yc_in = ROT_W'(py16 * geom_rd.cos_v);
   assign p_xs_in = ROT_W'(dx * geom_rd.sin_v);
   assign xr = p_xc_ff - p_ys_ff;
   assign yr = p_yc_ff + p_xs_ff;

   // Sample indices trunc(yr + 1) and the position between the two beams.
   assign t0 = yr0_ff + ROT_W'(1 << FRAC_W);
   assign t1 = yr1_ff + ROT_W'(1 << FRAC_W);
   assign ok0 = t0[ROT_W-1] ? (t0 > -ROT_W'(1 << FRAC_W))
                            : ((t0 >>> FRAC_W) < ROT_W'(SAMPLE_DEPTH));
   assign ok1 = t1[ROT_W-1] ? (t1 > -ROT_W'(1 << FRAC_W))
                            : ((t1 >>> FRAC_W) < ROT_W'(SAMPLE_DEPTH));
   assign dd   = CMP_W'(x0_ff) - CMP_W'(x1_ff);
   assign x0_4 = CMP_W'(x0_ff) <<< 2;
   assign d_3  = dd + (dd <<< 1);
   assign avg  = (9'(v0_ff) + 9'(samp_rd_data)) >> 1;

   // Sample reads: earlier beam first, then the later one.
   assign samp_rd_en = (state_ff == ST_RD0) || (state_ff == ST_RD1);
   assign samp_rd_addr = (state_ff == ST_RD0)
      ? SADDR_W'(beam_ff - BEAM_W'(1)) * SADDR_W'(SAMPLE_DEPTH) + SADDR_W'(n0_ff)
      : SADDR_W'(beam_ff) * SADDR_W'(SAMPLE_DEPTH) + SADDR_W'(n1_ff);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         beam_count_ff <= '0;
         valid_a_ff    <= 1'b0;
         valid_b_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_a_ff   <= valid_a_in;
         valid_b_ff   <= valid_b_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            beam_count_ff <= csr_wr_data;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      count_ff     <= count_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      issue_ff     <= issue_in;
      idx_a_ff     <= idx_a_in;
      idx_b_ff     <= idx_b_in;
      p_xc_ff      <= p_xc_in;
      p_ys_ff      <= p_ys_in;
      p_yc_ff      <= p_yc_in;
      p_xs_ff      <= p_xs_in;
      last_xr_ff   <= last_xr_in;
      last_yr_ff   <= last_yr_in;
      x0_ff        <= x0_in;
      x1_ff        <= x1_in;
      yr0_ff       <= yr0_in;
      yr1_ff       <= yr1_in;
      beam_ff      <= beam_in;
      n0_ff        <= n0_in;
      n1_ff        <= n1_in;
      sel_ff       <= sel_in;
      v0_ff        <= v0_in;
      result_ff    <= result_in;
      rsp_value_ff <= rsp_value_in;
   end

   // Sequencer: next state and datapath control.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      issue_in     = issue_ff;
      idx_a_in     = issue_ff;
      idx_b_in     = idx_a_ff;
      last_xr_in   = last_xr_ff;
      last_yr_in   = last_yr_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      yr0_in       = yr0_ff;
      yr1_in       = yr1_ff;
      beam_in      = beam_ff;
      n0_in        = n0_ff;
      n1_in        = n1_ff;
      sel_in       = sel_ff;
      v0_in        = v0_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;

      unique case (state_ff)
         ST_IDLE: begin
            px_in    = req_pixel_x;
            py_in    = req_pixel_y;
            issue_in = '0;
            count_in = (int'(beam_count_ff) > MAX_BEAMS) ? COUNT_W'(MAX_BEAMS)
                                                          : beam_count_ff;
            if (req_fire && (req_opcode == OP_RENDER)) begin
               if ((count_in < COUNT_W'(2)) || (int'(req_pixel_x) >= IMAGE_WIDTH)
                   || (int'(req_pixel_y) >= SAMPLE_DEPTH)) begin
                  result_in = BACKGROUND;
                  state_in  = ST_FINISH;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (geom_rd_en) begin
               issue_in = issue_ff + COUNT_W'(1);
            end
            if (valid_b_ff) begin
               if (xr < 0) begin
                  x0_in   = last_xr_ff;
                  yr0_in  = last_yr_ff;
                  x1_in   = xr;
                  yr1_in  = yr;
                  beam_in = idx_b_ff[BEAM_W-1:0];
                  if (idx_b_ff == '0) begin
                     result_in = BACKGROUND;
                     state_in  = ST_FINISH;
                  end else begin
                     state_in = ST_EVAL;
                  end
               end else begin
                  last_xr_in = xr;
                  last_yr_in = yr;
                  if (idx_b_ff == count_ff - COUNT_W'(1)) begin
                     result_in = BACKGROUND;
                     state_in  = ST_FINISH;
                  end
               end
            end
         end
         ST_EVAL: begin
            n0_in = t0[ROT_W-1] ? '0 : t0[FRAC_W +: SIDX_W];
            n1_in = t1[ROT_W-1] ? '0 : t1[FRAC_W +: SIDX_W];
            if (x0_4 < dd) begin
               sel_in = SEL_FIRST;
            end else if (x0_4 < d_3) begin
               sel_in = SEL_AVG;
            end else begin
               sel_in = SEL_SECOND;
            end
            if (ok0 && ok1) begin
               state_in = ST_RD0;
            end else begin
               result_in = BACKGROUND;
               state_in  = ST_FINISH;
            end
         end
         ST_RD0: begin
            state_in = ST_RD1;
         end
         ST_RD1: begin
            v0_in    = samp_rd_data;
            state_in = ST_CALC;
         end
         ST_CALC: begin
            unique case (sel_ff)
               SEL_FIRST:  result_in = (9'(v0_ff) > AMP_LIMIT) ? 8'(AMP_LIMIT) : v0_ff;
               SEL_AVG:    result_in = (avg > AMP_LIMIT) ? 8'(AMP_LIMIT) : avg[7:0];
               SEL_SECOND: result_in = (9'(samp_rd_data) > AMP_LIMIT) ? 8'(AMP_LIMIT)
                                                                      : samp_rd_data;
               default:    result_in = BACKGROUND;
            endcase
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = result_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // The walk pipeline only runs while the walk goes on.
      valid_a_in = geom_rd_en && (state_in == ST_WALK);
      valid_b_in = valid_a_ff && (state_in == ST_WALK);
   end

   `SCC_ASSERT_SAME(a_pipe_in_walk, clock, reset, valid_b_ff, state_ff == ST_WALK, "walk pipeline valid outside the walk")
   `SCC_ASSERT_NEXT(a_render_starts, clock, reset, req_fire && (req_opcode == OP_RENDER), state_ff != ST_IDLE, "render request did not start")
   `SCC_ASSERT_SAME(a_value_range, clock, reset, rsp_valid_ff, (rsp_value_ff <= 8'(AMP_LIMIT)) || (rsp_value_ff == BACKGROUND), "pixel value out of range")
   `SCC_ASSERT_NEXT(a_one_result, clock, reset, (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready), rsp_valid_ff && (state_ff == ST_IDLE), "finished pixel not delivered")

endmodule
